// File: rtl/core/sample_frame_crc16_packer_assert.svh
// Assertion macros shared by the sample frame packer RTL.
// Each macro expects clk and rst in scope at the point of use.
`ifndef SAMPLE_FRAME_CRC16_PACKER_ASSERT_SVH
`define SAMPLE_FRAME_CRC16_PACKER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SFCP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfcp assertion failed");

// Next-cycle implication, disabled during reset.
`define SFCP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfcp assertion failed");

`endif

// File: rtl/core/sfcp_pkg.sv
// Package for the sample frame packer: payload types, frame constants
// and the byte-wise CRC-16 (Modbus) update. No dependencies.
`default_nettype none

package sfcp_pkg;

  // Frame layout.
  localparam logic [3:0] DATA_LEN   = 4'd8;
  localparam logic [3:0] CRC_LO_POS = 4'd8;
  localparam logic [3:0] LAST_POS   = 4'd9;

  // Reflected CRC-16, Modbus flavor.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef struct packed {
    logic signed [15:0] channel_zero;
    logic signed [15:0] channel_one;
    logic signed [15:0] channel_two;
    logic signed [15:0] channel_three;
  } sample_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic [3:0] byte_position;
    logic       last_byte;
  } frame_t;

  // Folds one data byte into the CRC, one bit per step, LSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/sfcp_serializer.sv
// Frame serializer: holds one set of samples, sends ten bytes and builds
// the CRC a byte at a time as the data bytes go out. Uses sfcp_pkg.
`default_nettype none

module sfcp_serializer (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load_valid,
  output logic                  load_ready,
  input  wire sfcp_pkg::sample_t load_data,
  output logic                  frame_valid,
  input  wire logic             frame_ready,
  output sfcp_pkg::frame_t      frame
);

  logic [7:0][7:0] data_bytes;
  logic [3:0]      pos;
  logic [15:0]     crc;
  logic            busy;
  logic [7:0]      cur_byte;
  logic            xfer;
  logic            at_last;

  // Select the byte for the current position: samples, then CRC low, high.
  always_comb begin
    if (pos < sfcp_pkg::DATA_LEN) begin
      cur_byte = data_bytes[pos[2:0]];
    end else if (pos == sfcp_pkg::CRC_LO_POS) begin
      cur_byte = crc[7:0];
    end else begin
      cur_byte = crc[15:8];
    end
  end

  assign xfer       = busy && frame_ready;
  assign at_last    = (pos == sfcp_pkg::LAST_POS);
  assign load_ready = !busy || (xfer && at_last);

  assign frame_valid         = busy;
  assign frame.frame_byte    = cur_byte;
  assign frame.byte_position = pos;
  assign frame.last_byte     = at_last;

  // Control: busy flag and byte position.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= '0;
    end else if (load_valid && load_ready) begin
      busy <= 1'b1;
      pos  <= '0;
    end else if (xfer) begin
      if (at_last) begin
        busy <= 1'b0;
      end else begin
        pos <= pos + 4'd1;
      end
    end
  end

  // Payload: sample bytes low byte first, and the running CRC.
  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      data_bytes[0] <= load_data.channel_zero[7:0];
      data_bytes[1] <= load_data.channel_zero[15:8];
      data_bytes[2] <= load_data.channel_one[7:0];
      data_bytes[3] <= load_data.channel_one[15:8];
      data_bytes[4] <= load_data.channel_two[7:0];
      data_bytes[5] <= load_data.channel_two[15:8];
      data_bytes[6] <= load_data.channel_three[7:0];
      data_bytes[7] <= load_data.channel_three[15:8];
      crc           <= sfcp_pkg::CRC_INIT;
    end else if (xfer && (pos < sfcp_pkg::DATA_LEN)) begin
      crc <= sfcp_pkg::crc16_byte(crc, cur_byte);
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/sample_frame_crc16_packer.sv
// Top level of the sample frame packer: input holding register feeding the
// byte serializer. Uses sfcp_pkg, sfcp_serializer and the assertion header.
//
//   channel   direction  handshake                   payload
//   sample    in         sample_valid/sample_ready   sample (sfcp_pkg::sample_t)
//   frame     out        frame_valid/frame_ready     frame  (sfcp_pkg::frame_t)
//
// Each accepted sample set yields ten byte transfers, one per cycle at most.
// Sustained item rate is set by the single byte lane.
// A holding register takes the next item while the current frame is sent.
// Reset (rst, synchronous) clears both valid flags; no clearing pass.
// A stall on frame_ready holds the current byte and backs up into sample_ready.
`default_nettype none

`include "sample_frame_crc16_packer_assert.svh"

module sample_frame_crc16_packer (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              sample_valid,
  output logic                   sample_ready,
  input  wire sfcp_pkg::sample_t sample,
  output logic                   frame_valid,
  input  wire logic              frame_ready,
  output sfcp_pkg::frame_t       frame
);

  logic              hold_valid;
  sfcp_pkg::sample_t hold_item;
  logic              load_ready;
  logic              mid_frame;
  logic              last_xfer;

  assign sample_ready = !hold_valid;

  // Holding register: filled on a sample transfer, drained into the serializer.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (sample_valid && sample_ready) begin
      hold_valid <= 1'b1;
    end else if (hold_valid && load_ready) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      hold_item <= sample;
    end
  end

  sfcp_serializer u_serializer (
    .clk         (clk),
    .rst         (rst),
    .load_valid  (hold_valid),
    .load_ready  (load_ready),
    .load_data   (hold_item),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame)
  );

  // Shorthands for the checks below.
  assign mid_frame = (frame.byte_position != 4'd0);
  assign last_xfer = frame_valid && frame_ready && frame.last_byte;

  // A frame byte past the first always follows a byte of the same frame.
  `SFCP_ASSERT_NOW(a_pos_follows, frame_valid && mid_frame, $past(frame_valid))

  // A waiting item starts a new frame right after the last byte transfer.
  `SFCP_ASSERT_NEXT(a_next_frame, last_xfer && hold_valid, frame_valid && !mid_frame)

  // A sample transfer always lands in the holding register.
  `SFCP_ASSERT_NEXT(a_hold_fill, sample_valid && sample_ready, hold_valid && !sample_ready)

endmodule

`default_nettype wire

// File: tb/sample_frame_crc16_packer_test.sv
// Self-checking testbench for the sample frame packer. It predicts the ten-byte
// frame of each accepted sample set and compares every byte transfer with it.
// Depends on sfcp_pkg and the sample_frame_crc16_packer top level only.
`timescale 1ns / 100ps

module sample_frame_crc16_packer_test;

  localparam int FRAME_BYTES = 10;
  localparam int MAX_WAIT    = 12;
  localparam int RANDOM_SETS = 160;

  logic              clk;
  logic              rst;
  logic              sample_valid;
  logic              sample_ready;
  sfcp_pkg::sample_t sample;
  logic              frame_valid;
  logic              frame_ready;
  sfcp_pkg::frame_t  frame;

  // Bytes still owed by the block, oldest first.
  sfcp_pkg::frame_t  pending_bytes[$];
  int                error_count;
  // When set, neither side inserts wait cycles.
  bit                no_idle;

  sample_frame_crc16_packer u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .frame_valid  (frame_valid),
    .frame_ready  (frame_ready),
    .frame        (frame)
  );

  // Free-running 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5ms;
    $display("sample_frame_crc16_packer_test: errors");
    $finish;
  end

  // Number of idle cycles a side inserts before its next transfer.
  function automatic int draw_wait();
    if (no_idle) begin
      return 0;
    end
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // Reflected CRC-16 with the Modbus polynomial, computed one data bit at a time.
  function automatic logic [15:0] modbus_crc(input logic [7:0] data_bytes[FRAME_BYTES]);
    logic [15:0] crc;
    logic        feedback;
    crc = sfcp_pkg::CRC_INIT;
    for (int n = 0; n < int'(sfcp_pkg::DATA_LEN); n++) begin
      for (int b = 0; b < 8; b++) begin
        feedback = crc[0] ^ data_bytes[n][b];
        crc = crc >> 1;
        if (feedback) begin
          crc = crc ^ sfcp_pkg::CRC_POLY;
        end
      end
    end
    return crc;
  endfunction

  // Appends the ten bytes that one sample set must produce.
  task automatic queue_frame(input sfcp_pkg::sample_t s);
    logic [15:0]      words[4];
    logic [7:0]       data_bytes[FRAME_BYTES];
    logic [15:0]      crc;
    sfcp_pkg::frame_t fb;
    words[0] = s.channel_zero;
    words[1] = s.channel_one;
    words[2] = s.channel_two;
    words[3] = s.channel_three;
    for (int ch = 0; ch < 4; ch++) begin
      data_bytes[2 * ch]     = words[ch][7:0];
      data_bytes[2 * ch + 1] = words[ch][15:8];
    end
    data_bytes[sfcp_pkg::CRC_LO_POS] = 8'h00;
    data_bytes[sfcp_pkg::LAST_POS]   = 8'h00;
    crc = modbus_crc(data_bytes);
    data_bytes[sfcp_pkg::CRC_LO_POS] = crc[7:0];
    data_bytes[sfcp_pkg::LAST_POS]   = crc[15:8];
    for (int k = 0; k < FRAME_BYTES; k++) begin
      fb.frame_byte    = data_bytes[k];
      fb.byte_position = 4'(k);
      fb.last_byte     = (k == int'(sfcp_pkg::LAST_POS));
      pending_bytes.push_back(fb);
    end
  endtask

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string msg);
    error_count++;
    $display("%0t ns: %s", $time, msg);
  endtask

  // Both channels are watched in one process so that a sample transfer and a
  // byte transfer at the same edge are handled in a fixed order.
  always @(posedge clk) begin
    sfcp_pkg::frame_t want;
    if (!rst) begin
      if (sample_valid && sample_ready) begin
        queue_frame(sample);
      end
      if (frame_valid && frame_ready) begin
        if (pending_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte transfer 0x%0h", frame.frame_byte));
        end else begin
          want = pending_bytes.pop_front();
          if (frame.frame_byte !== want.frame_byte) begin
            report_mismatch($sformatf("frame_byte mismatch: got 0x%0h, expected 0x%0h",
                                      frame.frame_byte, want.frame_byte));
          end
          if (frame.byte_position !== want.byte_position) begin
            report_mismatch($sformatf("byte_position mismatch: got 0x%0h, expected 0x%0h",
                                      frame.byte_position, want.byte_position));
          end
          if (frame.last_byte !== want.last_byte) begin
            report_mismatch($sformatf("last_byte mismatch: got 0x%0h, expected 0x%0h",
                                      frame.last_byte, want.last_byte));
          end
        end
      end
    end
  end

  // Receiver: waits a random number of cycles, then stays ready until one
  // byte transfer has taken place.
  initial begin
    int stall;
    frame_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        frame_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      frame_ready <= 1'b1;
      do @(posedge clk); while (frame_valid !== 1'b1);
    end
  end

  // Sends one sample set. Valid is left high on return, so the next call in the
  // same step either replaces the payload or lowers valid for its gap.
  task automatic send_samples(input sfcp_pkg::sample_t s);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    do @(posedge clk); while (sample_ready !== 1'b1);
  endtask

  task automatic send_channels(input logic [15:0] c0, input logic [15:0] c1,
                               input logic [15:0] c2, input logic [15:0] c3);
    sfcp_pkg::sample_t s;
    s.channel_zero  = c0;
    s.channel_one   = c1;
    s.channel_two   = c2;
    s.channel_three = c3;
    send_samples(s);
  endtask

  // Stops sending and waits until every owed byte has been transferred.
  task automatic wait_drained();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
  endtask

  // Random sample value, leaning on the range limits now and then.
  function automatic logic [15:0] pick_channel();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Range limits, sign patterns and single set bits in one byte of each channel.
  task automatic test_directed();
    send_channels(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_channels(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_channels(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_channels(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_channels(16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001);
    send_channels(16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF);
    send_channels(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    send_channels(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    send_channels(16'h0001, 16'h0000, 16'h0000, 16'h0000);
    send_channels(16'h0000, 16'h0100, 16'h0000, 16'h0000);
    send_channels(16'h0000, 16'h0000, 16'h0080, 16'h0000);
    send_channels(16'h0000, 16'h0000, 16'h0000, 16'h8000);
    send_channels(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);
    send_channels(16'hFF00, 16'h00FF, 16'hF0F0, 16'h0F0F);
    wait_drained();
  endtask

  // Full-rate streaming with no idle cycles on either side.
  task automatic test_back_to_back();
    no_idle = 1'b1;
    for (int i = 0; i < 20; i++) begin
      send_channels(pick_channel(), pick_channel(), pick_channel(), pick_channel());
    end
    wait_drained();
    no_idle = 1'b0;
  endtask

  // The sender holds off until the block has emptied, then resumes.
  task automatic test_drain_pause();
    for (int i = 0; i < 3; i++) begin
      send_channels(pick_channel(), pick_channel(), pick_channel(), pick_channel());
    end
    wait_drained();
    for (int i = 0; i < 3; i++) begin
      send_channels(pick_channel(), pick_channel(), pick_channel(), pick_channel());
    end
  endtask

  // Random sample sets with random gaps, broken up by stretches at full rate.
  task automatic test_random();
    for (int i = 0; i < RANDOM_SETS; i++) begin
      no_idle = ((i % 50) >= 35);
      send_channels(pick_channel(), pick_channel(), pick_channel(), pick_channel());
    end
    no_idle = 1'b0;
  endtask

  // Main sequence: reset once, run each test, then settle and report.
  initial begin
    error_count  = 0;
    no_idle      = 1'b0;
    rst          <= 1'b1;
    sample_valid <= 1'b0;
    sample       <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_back_to_back();
    test_drain_pause();
    test_random();

    wait_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("sample_frame_crc16_packer_test: clean");
    end else begin
      $display("sample_frame_crc16_packer_test: errors");
    end
    $finish;
  end

endmodule
